FILE: src/rdmr_pkg.sv
// ----------------------------------------------------------------------------
// rdmr_pkg: shared types and constants for the region descriptor matcher
// field widths, register map, result codes, window and popcount helpers
// ----------------------------------------------------------------------------
package rdmr_pkg;

   // design constants
   localparam int DESC_BITS  = 256;
   localparam int COORD_FRAC = 4;
   localparam int INDEX_BITS = 10;

   // fixed field widths
   localparam int WORD_W     = 64;
   localparam int POS_W      = 16;
   localparam int HALF_W     = 12;
   localparam int DIM_W      = 13;
   localparam int THRESH_W   = 9;
   localparam int FACTOR_W   = 8;
   localparam int DIST_W     = 9;
   localparam int FLAG_W     = 2;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   // derived widths
   localparam int NUM_WORDS = (DESC_BITS + WORD_W - 1) / WORD_W;
   localparam int PAD_BITS  = NUM_WORDS * WORD_W;
   localparam int PC_W      = 7;
   localparam int RND_W     = POS_W + 1 - COORD_FRAC;
   localparam int EDGE_W    = (RND_W > HALF_W) ? RND_W : HALF_W;
   localparam int XW        = EDGE_W + COORD_FRAC;
   localparam int HALF_LSB  = (1 << COORD_FRAC) >> 1;
   localparam int PROD_W    = DIST_W + FACTOR_W;
   localparam int FRAC_ONE_SHIFT = 4;

   localparam int MAX_DIM = 4096;
   localparam logic [DIST_W-1:0] NO_DIST = DIST_W'(257);

   // register reset values
   localparam logic [DIM_W-1:0]    RST_IMG_COLS  = DIM_W'(640);
   localparam logic [DIM_W-1:0]    RST_IMG_ROWS  = DIM_W'(480);
   localparam logic [THRESH_W-1:0] RST_THRESHOLD = THRESH_W'(64);
   localparam logic [FACTOR_W-1:0] RST_FACTOR    = FACTOR_W'(20);

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic {
      CMD_QUERY = 1'b0,
      CMD_CAND  = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMG_COLS         = 2'd0,
      REG_IMG_ROWS         = 2'd1,
      REG_MATCH_THRESHOLD  = 2'd2,
      REG_AMBIGUITY_FACTOR = 2'd3
   } reg_index_type;

   typedef enum logic [FLAG_W-1:0] {
      FLAG_NO_FEATURES = 2'd0,
      FLAG_NO_MATCH    = 2'd1,
      FLAG_AMBIGUOUS   = 2'd2,
      FLAG_GOOD        = 2'd3
   } flag_type;

   typedef struct packed {
      logic                cmd;
      logic [WORD_W-1:0]   desc_word_0;
      logic [WORD_W-1:0]   desc_word_1;
      logic [WORD_W-1:0]   desc_word_2;
      logic [WORD_W-1:0]   desc_word_3;
      logic [POS_W-1:0]    pos_x;
      logic [POS_W-1:0]    pos_y;
      logic                skip_used;
      logic [HALF_W-1:0]   half_width;
      logic [HALF_W-1:0]   half_height;
      logic                last;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] best_index;
      logic [DIST_W-1:0]     top_dist;
      logic [DIST_W-1:0]     second_score;
      logic [FLAG_W-1:0]     grade;
   } rsp_payload_type;

   typedef struct packed {
      logic [DIM_W-1:0]    img_cols;
      logic [DIM_W-1:0]    img_rows;
      logic [THRESH_W-1:0] match_threshold;
      logic [FACTOR_W-1:0] ambiguity_factor;
   } cfg_type;

   // one classified item on its way to the back end
   typedef struct packed {
      logic                          is_cand;
      logic                          last;
      logic                          in_win;
      logic [NUM_WORDS-1:0][PC_W-1:0] word_pop;
   } q_entry_type;

   // round half up to whole pixels
   function automatic logic [RND_W-1:0] round_pos(input logic [POS_W-1:0] p);
      logic [POS_W:0] s;
      s = {1'b0, p} + (POS_W + 1)'(HALF_LSB);
      return RND_W'(s >> COORD_FRAC);
   endfunction

   // last valid coordinate of an image dimension, size clamped to 1..MAX_DIM
   function automatic logic [DIM_W-1:0] dim_last(input logic [DIM_W-1:0] r);
      logic [DIM_W-1:0] res;
      if (r == '0) begin
         res = '0;
      end else if (r > DIM_W'(MAX_DIM)) begin
         res = DIM_W'(MAX_DIM - 1);
      end else begin
         res = r - DIM_W'(1);
      end
      return res;
   endfunction

   function automatic logic [EDGE_W-1:0] lo_edge(input logic [RND_W-1:0] c,
                                                 input logic [HALF_W-1:0] h);
      logic [EDGE_W-1:0] ce;
      logic [EDGE_W-1:0] he;
      ce = EDGE_W'(c);
      he = EDGE_W'(h);
      return (ce > he) ? ce - he : '0;
   endfunction

   function automatic logic [EDGE_W-1:0] hi_edge(input logic [RND_W-1:0] c,
                                                 input logic [HALF_W-1:0] h,
                                                 input logic [DIM_W-1:0] lim);
      logic [EDGE_W:0] e;
      logic [EDGE_W:0] le;
      e  = (EDGE_W + 1)'(c) + (EDGE_W + 1)'(h);
      le = (EDGE_W + 1)'(lim);
      return (e > le) ? EDGE_W'(le) : EDGE_W'(e);
   endfunction

   // 64-bit popcount as eight byte counts and a short sum
   function automatic logic [PC_W-1:0] pop64(input logic [WORD_W-1:0] v);
      logic [3:0]      grp [8];
      logic [PC_W-1:0] total;
      for (int g = 0; g < 8; g++) begin
         grp[g] = '0;
         for (int b = 0; b < 8; b++) begin
            grp[g] = grp[g] + 4'(v[g*8 + b]);
         end
      end
      total = '0;
      for (int g = 0; g < 8; g++) begin
         total = total + PC_W'(grp[g]);
      end
      return total;
   endfunction

endpackage

FILE: src/rdmr_if.sv
// ----------------------------------------------------------------------------
// rdmr_if: request and response channels
// valid/ready handshake with a packed payload
// ----------------------------------------------------------------------------
interface rdmr_req_if import rdmr_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rdmr_rsp_if import rdmr_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/rdmr_front.sv
// ----------------------------------------------------------------------------
// rdmr_front: request intake and classification
// builds the search window, holds the query descriptor, scores window
// membership and per-word popcounts of candidates, pushes into the queue
// ----------------------------------------------------------------------------
module rdmr_front import rdmr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rdmr_req_if.sink     req_ch,
   input  cfg_type      cfg,
   input  logic         q_full,
   output logic         push_valid,
   output q_entry_type  push_entry
);

   logic                 accept;
   logic                 is_cand;
   logic [RND_W-1:0]     cx;
   logic [RND_W-1:0]     cy;
   logic [XW-1:0]        px;
   logic [XW-1:0]        lx;
   logic [XW-1:0]        rx;
   logic [EDGE_W-1:0]    row;
   logic                 in_win;
   logic [DESC_BITS-1:0] desc_in;
   logic [PAD_BITS-1:0]  xor_pad;

   logic [DESC_BITS-1:0] qdesc_ff;
   logic [EDGE_W-1:0]    win_left_ff;
   logic [EDGE_W-1:0]    win_right_ff;
   logic [EDGE_W-1:0]    win_top_ff;
   logic [EDGE_W-1:0]    win_bottom_ff;

   logic                 s1_valid_ff;
   logic                 s1_is_cand_ff;
   logic                 s1_last_ff;
   logic                 s1_in_win_ff;
   logic [DESC_BITS-1:0] s1_xor_ff;

   assign req_ch.ready = !s1_valid_ff || !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_cand      = (req_ch.data.cmd == CMD_CAND);

   always_comb begin
      desc_in = DESC_BITS'({req_ch.data.desc_word_3, req_ch.data.desc_word_2,
                            req_ch.data.desc_word_1, req_ch.data.desc_word_0});
      cx  = round_pos(req_ch.data.pos_x);
      cy  = round_pos(req_ch.data.pos_y);
      // columns compared in fixed point, rows after rounding
      px  = XW'(req_ch.data.pos_x);
      lx  = XW'(win_left_ff) << COORD_FRAC;
      rx  = XW'(win_right_ff) << COORD_FRAC;
      row = EDGE_W'(cy);
      in_win = !req_ch.data.skip_used && (px >= lx) && (px <= rx)
               && (row >= win_top_ff) && (row <= win_bottom_ff);
   end

   // query state
   always_ff @(posedge clock) begin
      if (reset) begin
         qdesc_ff      <= '0;
         win_left_ff   <= '0;
         win_right_ff  <= '0;
         win_top_ff    <= '0;
         win_bottom_ff <= '0;
      end else if (accept && !is_cand) begin
         qdesc_ff      <= desc_in;
         win_left_ff   <= lo_edge(cx, req_ch.data.half_width);
         win_right_ff  <= hi_edge(cx, req_ch.data.half_width, dim_last(cfg.img_cols));
         win_top_ff    <= lo_edge(cy, req_ch.data.half_height);
         win_bottom_ff <= hi_edge(cy, req_ch.data.half_height, dim_last(cfg.img_rows));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (!q_full) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_is_cand_ff <= is_cand;
         s1_last_ff    <= req_ch.data.last;
         s1_in_win_ff  <= in_win;
         s1_xor_ff     <= desc_in ^ qdesc_ff;
      end
   end

   always_comb begin
      xor_pad            = PAD_BITS'(s1_xor_ff);
      push_valid         = s1_valid_ff;
      push_entry.is_cand = s1_is_cand_ff;
      push_entry.last    = s1_last_ff;
      push_entry.in_win  = s1_in_win_ff;
      for (int i = 0; i < NUM_WORDS; i++) begin
         push_entry.word_pop[i] = pop64(xor_pad[i*WORD_W +: WORD_W]);
      end
   end

endmodule

FILE: src/rdmr_fifo.sv
// ----------------------------------------------------------------------------
// rdmr_fifo: short queue between front and back
// first-word-fall-through, push only when not full
// ----------------------------------------------------------------------------
module rdmr_fifo import rdmr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  q_entry_type  push_entry,
   input  logic         pop,
   output q_entry_type  head,
   output logic         full,
   output logic         empty
);

   q_entry_type        mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff;

   assign full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + Q_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - Q_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   overflow_check: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   underflow_check: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

   count_check: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !empty)
      else $error("queue lost an entry");

endmodule

FILE: src/rdmr_back.sv
// ----------------------------------------------------------------------------
// rdmr_back: scoring and result generation
// sums word popcounts, tracks best and second-best distances, snapshots
// the running result on last and grades it in the output register
// ----------------------------------------------------------------------------
module rdmr_back import rdmr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  q_entry_type  head,
   input  logic         q_empty,
   output logic         pop,
   rdmr_rsp_if.source   rsp_ch
);

   typedef struct packed {
      logic                  found;
      logic [INDEX_BITS-1:0] ordinal;
      logic [DIST_W-1:0]     best;
      logic [DIST_W-1:0]     second;
   } snap_type;

   logic [DIST_W-1:0]     cand_dist;
   logic                  out_can;
   logic                  rpt_can;
   logic                  rpt_move;

   logic [DIST_W-1:0]     best_ff,   best_in;
   logic [DIST_W-1:0]     second_ff, second_in;
   logic [INDEX_BITS-1:0] ord_ff,    ord_in;
   logic [INDEX_BITS-1:0] cnt_ff,    cnt_in;
   logic                  found_ff,  found_in;

   logic                  rpt_valid_ff;
   snap_type              rpt_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff, rsp_data_in;
   logic [PROD_W-1:0]     prod;
   logic [PROD_W-1:0]     rhs;

   assign out_can  = !rsp_valid_ff || rsp_ch.ready;
   assign rpt_move = rpt_valid_ff && out_can;
   assign rpt_can  = !rpt_valid_ff || out_can;
   assign pop      = !q_empty && (!head.last || rpt_can);

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   always_comb begin
      cand_dist = '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
         cand_dist = cand_dist + DIST_W'(head.word_pop[i]);
      end
   end

   // running search state
   always_comb begin
      best_in   = best_ff;
      second_in = second_ff;
      ord_in    = ord_ff;
      cnt_in    = cnt_ff;
      found_in  = found_ff;
      if (!head.is_cand) begin
         best_in   = NO_DIST;
         second_in = NO_DIST;
         ord_in    = '0;
         cnt_in    = '0;
         found_in  = 1'b0;
      end else begin
         cnt_in = cnt_ff + INDEX_BITS'(1);
         if (head.in_win && (cand_dist < best_ff)) begin
            second_in = best_ff;
            best_in   = cand_dist;
            ord_in    = cnt_ff;
            found_in  = 1'b1;
         end else if (head.in_win && (cand_dist < second_ff)) begin
            second_in = cand_dist;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff   <= NO_DIST;
         second_ff <= NO_DIST;
         ord_ff    <= '0;
         cnt_ff    <= '0;
         found_ff  <= 1'b0;
      end else if (pop) begin
         best_ff   <= best_in;
         second_ff <= second_in;
         ord_ff    <= ord_in;
         cnt_ff    <= cnt_in;
         found_ff  <= found_in;
      end
   end

   // report snapshot
   always_ff @(posedge clock) begin
      if (reset) begin
         rpt_valid_ff <= 1'b0;
      end else if (pop && head.last) begin
         rpt_valid_ff <= 1'b1;
      end else if (rpt_move) begin
         rpt_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.last) begin
         rpt_ff.found   <= found_in;
         rpt_ff.ordinal <= ord_in;
         rpt_ff.best    <= best_in;
         rpt_ff.second  <= second_in;
      end
   end

   // grading: threshold, then ratio test best*factor against second*1.0
   always_comb begin
      prod = PROD_W'(rpt_ff.best) * PROD_W'(cfg.ambiguity_factor);
      rhs  = PROD_W'(rpt_ff.second) << FRAC_ONE_SHIFT;
      if (!rpt_ff.found) begin
         rsp_data_in.best_index   = '0;
         rsp_data_in.top_dist     = '0;
         rsp_data_in.second_score = NO_DIST;
         rsp_data_in.grade        = FLAG_NO_FEATURES;
      end else begin
         rsp_data_in.best_index   = rpt_ff.ordinal;
         rsp_data_in.top_dist     = rpt_ff.best;
         rsp_data_in.second_score = rpt_ff.second;
         if (rpt_ff.best > cfg.match_threshold) begin
            rsp_data_in.grade = FLAG_NO_MATCH;
         end else if (prod >= rhs) begin
            rsp_data_in.grade = FLAG_AMBIGUOUS;
         end else begin
            rsp_data_in.grade = FLAG_GOOD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rpt_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rpt_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   empty_search_check: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> (best_ff == NO_DIST) && (second_ff == NO_DIST))
      else $error("distances set with no candidate found");

   order_check: assert property (@(posedge clock) disable iff (reset)
      best_ff <= second_ff)
      else $error("second-best distance below best");

   snapshot_hold_check: assert property (@(posedge clock) disable iff (reset)
      rpt_valid_ff && !out_can |=> rpt_valid_ff && $stable(rpt_ff))
      else $error("pending report changed while output stalled");

   last_pop_check: assert property (@(posedge clock) disable iff (reset)
      pop && head.last |-> rpt_can)
      else $error("report overwritten before it moved on");

endmodule

FILE: src/region_descriptor_match_ratio_top.sv
// ----------------------------------------------------------------------------
// region_descriptor_match_ratio_top: windowed binary descriptor matcher
// brute-force hamming search over a candidate stream with a ratio test
// ----------------------------------------------------------------------------
// A query request (cmd 0) loads a 256-bit descriptor and a 12.4 position with
// half sizes; the window around the rounded position is clamped to the image
// set in the csr registers. Candidate requests (cmd 1) follow; each one inside
// the window with skip_used clear is scored by hamming distance, and the
// request carrying last produces one response with the best ordinal, best and
// second-best distances and a grade (no features, no match, ambiguous, good).
// Requests are taken one per clock cycle sustained while the queue has room: the
// front end registers the xor against the stored descriptor, takes per-word
// popcounts into a two-entry queue, and the back end sums them and updates the
// running best as it pops each entry, so a candidate can follow a query or
// another candidate on the next cycle. After the edge that takes its last
// request, a response passes through the intake register, queue, report
// snapshot and graded output register, and a waiting response does not block
// new requests until the report snapshot behind it is also occupied and
// another last request reaches the back end. There is no clearing pass after reset.
// CSR writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module region_descriptor_match_ratio_top import rdmr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rdmr_req_if.sink              req_ch,
   rdmr_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   cfg_type     cfg_ff;

   // front to queue
   logic        push_valid;
   q_entry_type push_entry;
   logic        q_full;

   // queue to back
   q_entry_type head;
   logic        q_empty;
   logic        pop;

   // csr writes, each register keeps the low bits of the write data
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.img_cols         <= RST_IMG_COLS;
         cfg_ff.img_rows         <= RST_IMG_ROWS;
         cfg_ff.match_threshold  <= RST_THRESHOLD;
         cfg_ff.ambiguity_factor <= RST_FACTOR;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_IMG_COLS: begin
               cfg_ff.img_cols <= DIM_W'(csr_wdata);
            end
            REG_IMG_ROWS: begin
               cfg_ff.img_rows <= DIM_W'(csr_wdata);
            end
            REG_MATCH_THRESHOLD: begin
               cfg_ff.match_threshold <= THRESH_W'(csr_wdata);
            end
            REG_AMBIGUITY_FACTOR: begin
               cfg_ff.ambiguity_factor <= FACTOR_W'(csr_wdata);
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // intake, window and popcounts
   rdmr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // decouples intake from scoring
   rdmr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid && !q_full),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   // best tracking and responses
   rdmr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (head),
      .q_empty (q_empty),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

FILE: tb/rdmr_match_tracker_pkg.sv
// ----------------------------------------------------------------------------
// rdmr_match_tracker_pkg: expected report tracking for the descriptor matcher
// follows the search state request by request and grades each candidate list
// ----------------------------------------------------------------------------
package rdmr_match_tracker_pkg;
   import rdmr_pkg::*;

   class match_tracker;
      cfg_type              regs;
      logic [DESC_BITS-1:0] query_desc;
      int unsigned          win_l, win_r, win_t, win_b;
      int unsigned          top_sc, second_score, best_ord, cand_count;
      bit                   found;
      rsp_payload_type      expected_reports[$];
      int unsigned          fail_count;

      function new();
         regs.img_cols         = RST_IMG_COLS;
         regs.img_rows         = RST_IMG_ROWS;
         regs.match_threshold  = RST_THRESHOLD;
         regs.ambiguity_factor = RST_FACTOR;
         query_desc = '0;
         win_l = 0;
         win_r = 0;
         win_t = 0;
         win_b = 0;
         fail_count = 0;
         clear_search();
      endfunction

      function void clear_search();
         top_sc       = NO_DIST;
         second_score = NO_DIST;
         best_ord     = 0;
         cand_count   = 0;
         found        = 1'b0;
      endfunction

      function void set_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_IMG_COLS:         regs.img_cols         = DIM_W'(value);
            REG_IMG_ROWS:         regs.img_rows         = DIM_W'(value);
            REG_MATCH_THRESHOLD:  regs.match_threshold  = THRESH_W'(value);
            REG_AMBIGUITY_FACTOR: regs.ambiguity_factor = FACTOR_W'(value);
            default: ;
         endcase
      endfunction

      // whole pixels, half up
      function int unsigned to_pixel(logic [POS_W-1:0] p);
         return (32'(p) + ((1 << COORD_FRAC) >> 1)) >> COORD_FRAC;
      endfunction

      // usable image size: zero acts as one, oversize saturates
      function int unsigned image_span(logic [DIM_W-1:0] size);
         if (size == 0) return 1;
         return (size > MAX_DIM) ? MAX_DIM : size;
      endfunction

      function rsp_payload_type grade_search();
         rsp_payload_type rep;
         rep.best_index   = INDEX_BITS'(best_ord);
         rep.top_dist     = DIST_W'(top_sc);
         rep.second_score = DIST_W'(second_score);
         if (!found) begin
            rep.best_index   = '0;
            rep.top_dist     = '0;
            rep.second_score = NO_DIST;
            rep.grade        = FLAG_NO_FEATURES;
         end else if (top_sc > regs.match_threshold) begin
            rep.grade = FLAG_NO_MATCH;
         end else if (top_sc * regs.ambiguity_factor >=
                      (second_score << FRAC_ONE_SHIFT)) begin
            rep.grade = FLAG_AMBIGUOUS;
         end else begin
            rep.grade = FLAG_GOOD;
         end
         return rep;
      endfunction

      function void note_request(req_payload_type r);
         logic [4*WORD_W-1:0] words;
         int unsigned cx, cy, hw, hh, w_max, h_max, px, row, ord, score;
         words = {r.desc_word_3, r.desc_word_2, r.desc_word_1, r.desc_word_0};
         if (r.cmd == CMD_QUERY) begin
            cx    = to_pixel(r.pos_x);
            cy    = to_pixel(r.pos_y);
            hw    = r.half_width;
            hh    = r.half_height;
            w_max = image_span(regs.img_cols) - 1;
            h_max = image_span(regs.img_rows) - 1;
            query_desc = words[DESC_BITS-1:0];
            win_l = (cx > hw) ? cx - hw : 0;
            win_r = (cx + hw > w_max) ? w_max : cx + hw;
            win_t = (cy > hh) ? cy - hh : 0;
            win_b = (cy + hh > h_max) ? h_max : cy + hh;
            clear_search();
         end else begin
            ord        = cand_count;
            cand_count = (cand_count + 1) % (1 << INDEX_BITS);
            px         = r.pos_x;
            row        = to_pixel(r.pos_y);
            // columns compare in fixed point, rows after rounding
            if (!r.skip_used && px >= (win_l << COORD_FRAC) && px <= (win_r << COORD_FRAC)
                && row >= win_t && row <= win_b) begin
               score = $countones(words[DESC_BITS-1:0] ^ query_desc);
               if (score < top_sc) begin
                  second_score = top_sc;
                  top_sc       = score;
                  best_ord     = ord;
                  found        = 1'b1;
               end else if (score < second_score) begin
                  second_score = score;
               end
            end
         end
         if (r.last) expected_reports.push_back(grade_search());
      endfunction

      function void field_check(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_report(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_reports.size() == 0) begin
            $error("unexpected response: index %0d top %0d second %0d grade %0d",
                   got.best_index, got.top_dist, got.second_score, got.grade);
            fail_count++;
            return;
         end
         want = expected_reports.pop_front();
         field_check("best_index", 16'(want.best_index), 16'(got.best_index));
         field_check("top_dist", 16'(want.top_dist), 16'(got.top_dist));
         field_check("second_score", 16'(want.second_score), 16'(got.second_score));
         field_check("grade", 16'(want.grade), 16'(got.grade));
      endfunction

      function int unsigned pending();
         return expected_reports.size();
      endfunction
   endclass

endpackage

FILE: tb/region_descriptor_match_ratio_top_test.sv
// ----------------------------------------------------------------------------
// region_descriptor_match_ratio_top_test: self-checking bench for the matcher
// directed window, tie and grading cases, then random query/candidate lists
// under several image settings with sender gaps and receiver back-pressure
// ----------------------------------------------------------------------------
module region_descriptor_match_ratio_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rdmr_pkg::*;
   import rdmr_match_tracker_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 7;
   localparam int LIMIT_CYCLES   = 400000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int PHASE_REQUESTS = 150;
   localparam int N_PHASES       = 6;
   localparam int WRAP_PHASE     = 4;
   localparam int WRAP_LIST      = 1100;

   // width, height, threshold, ambiguity factor per phase
   localparam int unsigned PHASE_REGS [N_PHASES][4] = '{
      '{640, 480, 64, 20},
      '{4096, 4096, 256, 255},
      '{1, 1, 0, 0},
      '{0, 8191, 511, 16},
      '{8191, 0, 100, 32},
      '{320, 240, 40, 24}
   };
   localparam int SEND_IDLE [N_PHASES]  = '{0, 64, 0, 29, 0, 0};
   localparam int RECV_STALL [N_PHASES] = '{0, 0, 64, 29, 0, 64};

   typedef logic [4*WORD_W-1:0] desc_bits_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned cycle_count = 0;

   match_tracker tracker = new();

   rdmr_req_if req_ch ();
   rdmr_rsp_if rsp_ch ();

   region_descriptor_match_ratio_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // response side: check on each handshake, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_report(rsp_ch.data);
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   function automatic desc_bits_type random_desc();
      desc_bits_type d;
      for (int i = 0; i < 8; i++) d[i*32 +: 32] = $urandom;
      return d;
   endfunction

   // flips up to count random bits (repeats may cancel)
   function automatic desc_bits_type flip_bits(desc_bits_type d, int unsigned count);
      int unsigned pos;
      for (int i = 0; i < count; i++) begin
         pos = $urandom_range(4*WORD_W - 1);
         d[pos] = ~d[pos];
      end
      return d;
   endfunction

   // flips exactly the low n bits, for a known distance
   function automatic desc_bits_type flip_low(desc_bits_type d, int unsigned n);
      return d ^ ((desc_bits_type'(1) << n) - 1);
   endfunction

   // fixed-point position from a pixel and a signed fraction offset, clamped
   function automatic logic [POS_W-1:0] fixed_pos(int pixel, int frac);
      int v;
      v = pixel * (1 << COORD_FRAC) + frac;
      if (v < 0) v = 0;
      if (v > (1 << POS_W) - 1) v = (1 << POS_W) - 1;
      return POS_W'(v);
   endfunction

   function automatic req_payload_type make_item(cmd_type cmd, desc_bits_type d,
                                                 logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                                 logic skip, logic [HALF_W-1:0] hw,
                                                 logic [HALF_W-1:0] hh, logic is_last);
      req_payload_type r;
      r.cmd         = cmd;
      r.desc_word_0 = d[0 +: WORD_W];
      r.desc_word_1 = d[WORD_W +: WORD_W];
      r.desc_word_2 = d[2*WORD_W +: WORD_W];
      r.desc_word_3 = d[3*WORD_W +: WORD_W];
      r.pos_x       = px;
      r.pos_y       = py;
      r.skip_used   = skip;
      r.half_width  = hw;
      r.half_height = hh;
      r.last        = is_last;
      return r;
   endfunction

   // present one request with random idle cycles ahead of it; valid stays
   // high on return so back-to-back requests need no extra edge
   task automatic send_request(input req_payload_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(r);
      requests_sent++;
   endtask

   // stop sending, wait for every outstanding report, then let the pipe empty
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all four registers, one write per edge, enable dropped once at the end
   task automatic load_settings(input int unsigned vals [4]);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= reg_index_type'(i);
         csr_wdata <= CSR_DATA_W'(vals[i]);
         @(posedge clock);
         tracker.set_register(reg_index_type'(i), CSR_DATA_W'(vals[i]));
      end
      csr_wr_en <= 1'b0;
   endtask

   // one well-formed search: a query, then n_cand candidates clustered around
   // its window so that edges, skips, ties and near-threshold scores all occur
   task automatic run_search(input int n_cand, input int skip_below);
      desc_bits_type     qd, cd, prev_d;
      logic [POS_W-1:0]  qx, qy;
      logic [HALF_W-1:0] hw, hh;
      int                w_span, h_span, cx, cy, reach_x, reach_y, col, row;
      int unsigned       pick;
      w_span = tracker.image_span(tracker.regs.img_cols);
      h_span = tracker.image_span(tracker.regs.img_rows);
      qd     = random_desc();
      prev_d = qd;
      // center mostly in the image, now and then anywhere in the field range
      if ($urandom_range(9) == 0) begin
         qx = POS_W'($urandom);
         qy = POS_W'($urandom);
      end else begin
         qx = fixed_pos($urandom_range(w_span - 1), $urandom_range(15));
         qy = fixed_pos($urandom_range(h_span - 1), $urandom_range(15));
      end
      hw = ($urandom_range(4) == 0) ? HALF_W'($urandom) : HALF_W'($urandom_range(8));
      hh = ($urandom_range(4) == 0) ? HALF_W'($urandom) : HALF_W'($urandom_range(8));
      send_request(make_item(CMD_QUERY, qd, qx, qy, 1'($urandom), hw, hh, n_cand == 0));
      cx      = tracker.to_pixel(qx);
      cy      = tracker.to_pixel(qy);
      reach_x = ((hw > 12) ? 12 : int'(hw)) + 2;
      reach_y = ((hh > 12) ? 12 : int'(hh)) + 2;
      for (int i = 0; i < n_cand; i++) begin
         col  = cx - reach_x + int'($urandom_range(2 * reach_x));
         row  = cy - reach_y + int'($urandom_range(2 * reach_y));
         pick = $urandom_range(9);
         // close matches, scores around the threshold, repeats for ties,
         // unrelated descriptors and near-complements
         if (pick < 3) cd = flip_bits(qd, $urandom_range(12));
         else if (pick < 6) cd = flip_bits(qd, $urandom_range(100));
         else if (pick < 8) cd = prev_d;
         else if (pick == 8) cd = random_desc();
         else cd = flip_bits(~qd, $urandom_range(3));
         prev_d = cd;
         send_request(make_item(CMD_CAND, cd,
                                fixed_pos(col, ($urandom_range(1) == 0) ? 0 : $urandom_range(15)),
                                fixed_pos(row, int'($urandom_range(15)) - 8),
                                (i < skip_below) || ($urandom_range(7) == 0),
                                HALF_W'($urandom), HALF_W'($urandom), i == n_cand - 1));
      end
   endtask

   // stray requests: random queries or candidates with random last
   task automatic send_noise();
      int unsigned n;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         send_request(make_item(cmd_type'($urandom_range(1)), random_desc(),
                                POS_W'($urandom), POS_W'($urandom), 1'($urandom),
                                HALF_W'($urandom), HALF_W'($urandom), 1'($urandom)));
      end
   endtask

   initial begin
      desc_bits_type qd;
      int unsigned   phase_start;
      int unsigned   pick;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, reset register values (640 x 480, 64, 20) ----

      // query carrying last: empty list, no-features report right away
      send_request(make_item(CMD_QUERY, '1, '1, '1, 1'b0, '1, '1, 1'b1));

      // window: x 100.5 rounds up to 101 -> cols 96..106,
      // y 50.44 rounds down to 50 -> rows 47..53
      qd = random_desc();
      send_request(make_item(CMD_QUERY, qd, fixed_pos(100, 8), fixed_pos(50, 7),
                             1'b0, 12'd5, 12'd3, 1'b0));
      // exactly on the left edge, score 10
      send_request(make_item(CMD_CAND, flip_low(qd, 10), fixed_pos(96, 0), fixed_pos(50, 0),
                             1'b0, '0, '0, 1'b0));
      // one lsb left of the edge, perfect descriptor must not count
      send_request(make_item(CMD_CAND, qd, fixed_pos(96, -1), fixed_pos(50, 0),
                             1'b0, '0, '0, 1'b0));
      // on the right edge, ties the best: becomes second
      send_request(make_item(CMD_CAND, flip_low(qd, 10), fixed_pos(106, 0), fixed_pos(50, 0),
                             1'b0, '0, '0, 1'b0));
      // one lsb past the right edge
      send_request(make_item(CMD_CAND, qd, fixed_pos(106, 1), fixed_pos(50, 0),
                             1'b0, '0, '0, 1'b0));
      // already used elsewhere, ignored though perfect
      send_request(make_item(CMD_CAND, qd, fixed_pos(100, 0), fixed_pos(50, 0),
                             1'b1, '0, '0, 1'b0));
      // bottom row reached by rounding down, new best of 3
      send_request(make_item(CMD_CAND, flip_low(qd, 3), fixed_pos(100, 0), fixed_pos(53, 7),
                             1'b0, '0, '0, 1'b0));
      // rounds up to the row below the window
      send_request(make_item(CMD_CAND, qd, fixed_pos(100, 0), fixed_pos(53, 8),
                             1'b0, '0, '0, 1'b0));
      // top row reached by rounding up; score between best and second, last
      send_request(make_item(CMD_CAND, flip_low(qd, 6), fixed_pos(100, 0), fixed_pos(47, -8),
                             1'b0, '0, '0, 1'b1));
      // candidate after last keeps scoring: ties best, ratio now ambiguous
      send_request(make_item(CMD_CAND, flip_low(qd, 3), fixed_pos(100, 0), fixed_pos(50, 0),
                             1'b0, '0, '0, 1'b1));
      // just above the top row; repeated report of running totals
      send_request(make_item(CMD_CAND, qd, fixed_pos(100, 0), fixed_pos(47, -9),
                             1'b0, '0, '0, 1'b1));

      // single-pixel window at the origin, worst possible score -> no match
      send_request(make_item(CMD_QUERY, '0, '0, '0, 1'b0, '0, '0, 1'b0));
      send_request(make_item(CMD_CAND, '1, '0, '0, 1'b0, '0, '0, 1'b1));

      // center past the image edge: left edge beyond right edge, window empty
      send_request(make_item(CMD_QUERY, '1, '1, '0, 1'b0, '0, '0, 1'b0));
      send_request(make_item(CMD_CAND, '1, '1, '0, 1'b0, '0, '0, 1'b1));

      // huge halves clamp to the whole image; score at the threshold is good,
      // one above it as second makes the ratio ambiguous
      qd = random_desc();
      send_request(make_item(CMD_QUERY, qd, fixed_pos(639, 0), '0, 1'b0, '1, '1, 1'b0));
      send_request(make_item(CMD_CAND, flip_low(qd, 64), fixed_pos(639, 0), fixed_pos(479, 0),
                             1'b0, '0, '0, 1'b0));
      send_request(make_item(CMD_CAND, flip_low(qd, 65), '0, '0, 1'b0, '0, '0, 1'b1));

      // this drain is also the hold-off until every report is back
      drain();

      // ---- random part: register settings and idling change per phase ----
      for (int p = 0; p < N_PHASES; p++) begin
         load_settings(PHASE_REGS[p]);
         send_idle_pct  = SEND_IDLE[p];
         recv_stall_pct = RECV_STALL[p];
         // one list past 2^INDEX_BITS candidates so the best ordinal wraps
         if (p == WRAP_PHASE) run_search(WRAP_LIST, 1 << INDEX_BITS);
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            pick = $urandom_range(19);
            if (pick < 2) send_noise();
            else if (pick == 2) run_search(0, 0);
            else if (pick == 3) run_search($urandom_range(13, 60), 0);
            else run_search($urandom_range(1, 12), 0);
         end
         drain();
      end

      if (tracker.fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/rdmr_pkg.sv
src/rdmr_if.sv
src/rdmr_front.sv
src/rdmr_fifo.sv
src/rdmr_back.sv
src/region_descriptor_match_ratio_top.sv
tb/rdmr_match_tracker_pkg.sv
tb/region_descriptor_match_ratio_top_test.sv
